// ===== hdl/gwdv_pkg.sv =====
package gwdv_pkg;

    localparam int WINDOW_LEN_DEF = 10;

    localparam int COORD_W = 14;
    localparam int EDGE_W  = 12;
    localparam int THR_W   = 4;
    localparam int DIR_W   = 3;
    localparam int CHAR_W  = 6;
    localparam int IDX_W   = 4;

    // plausibility limits of one eye coordinate
    localparam logic signed [COORD_W-1:0] COORD_MIN = -14'sd1000;
    localparam logic signed [COORD_W-1:0] X_MAX     = 14'sd3560;
    localparam logic signed [COORD_W-1:0] Y_MAX     = 14'sd2440;

    localparam logic [IDX_W-1:0] REG_LEFT_EDGE     = 4'd0;
    localparam logic [IDX_W-1:0] REG_RIGHT_EDGE    = 4'd1;
    localparam logic [IDX_W-1:0] REG_TOP_EDGE      = 4'd2;
    localparam logic [IDX_W-1:0] REG_BOTTOM_EDGE   = 4'd3;
    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd4;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd5;
    localparam logic [IDX_W-1:0] REG_VOTE_THR      = 4'd6;
    localparam logic [IDX_W-1:0] REG_HOLD_THR      = 4'd7;

    localparam logic [DIR_W-1:0] DIR_STOP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP      = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd4;
    localparam logic [DIR_W-1:0] DIR_UPLEFT  = 3'd5;
    localparam logic [DIR_W-1:0] DIR_UPRIGHT = 3'd6;
    localparam logic [DIR_W-1:0] DIR_BRAKE   = 3'd7;

    // keypad digits in ASCII
    localparam logic [CHAR_W-1:0] CHAR_STOP    = 6'd53;
    localparam logic [CHAR_W-1:0] CHAR_LEFT    = 6'd52;
    localparam logic [CHAR_W-1:0] CHAR_RIGHT   = 6'd54;
    localparam logic [CHAR_W-1:0] CHAR_UP      = 6'd56;
    localparam logic [CHAR_W-1:0] CHAR_DOWN    = 6'd50;
    localparam logic [CHAR_W-1:0] CHAR_UPLEFT  = 6'd57;
    localparam logic [CHAR_W-1:0] CHAR_UPRIGHT = 6'd55;
    localparam logic [CHAR_W-1:0] CHAR_BRAKE   = 6'd48;

    typedef struct packed {
        logic [EDGE_W-1:0] left_edge;
        logic [EDGE_W-1:0] right_edge;
        logic [EDGE_W-1:0] top_edge;
        logic [EDGE_W-1:0] bottom_edge;
        logic [EDGE_W-1:0] screen_width;
        logic [EDGE_W-1:0] screen_height;
        logic [THR_W-1:0]  vote_threshold;
        logic [THR_W-1:0]  hold_threshold;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      good;
    } t_entry;

    typedef struct packed {
        logic left;
        logic right;
        logic up;
        logic down;
        logic upleft;
        logic upright;
        logic out;
    } t_flags;

    function automatic logic [CHAR_W-1:0] dir_char(input logic [DIR_W-1:0] dir);
        logic [CHAR_W-1:0] c;
        case (dir)
            DIR_STOP:    c = CHAR_STOP;
            DIR_LEFT:    c = CHAR_LEFT;
            DIR_RIGHT:   c = CHAR_RIGHT;
            DIR_UP:      c = CHAR_UP;
            DIR_DOWN:    c = CHAR_DOWN;
            DIR_UPLEFT:  c = CHAR_UPLEFT;
            DIR_UPRIGHT: c = CHAR_UPRIGHT;
            DIR_BRAKE:   c = CHAR_BRAKE;
            default:     c = CHAR_STOP;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/gaze_window_direction_vote.sv =====
// Binocular gaze direction voter.
// Slave stream (s_axis): one binocular gaze sample per transaction.
// Master stream (m_axis): one direction command per plausible sample; a sample
// whose eyes are both implausible in x or in y enters the window as an invalid
// mark and yields no transaction.
// Config channel: write register index and data while the block is idle;
// always ready, applied at the next edge.
// The window is a chain of WINDOW_LEN cells; each accepted sample shifts in at
// the head and the oldest falls off the tail. Region counts are taken across
// the cells at the edge the vote is registered.
// Path: an accepted sample waits in the pending slot, then the output register
// drives m_axis_tvalid. Throughput: one sample per cycle while the output is not
// stalled, by a combinational vote over the cell chain; a pending slot in front
// of the output register lets a new sample enter while a finished command still waits.
// Reset: window fill count cleared, held direction stop, registers at their
// defaults, both streams empty.
// Stall: while the output holds a command that m_axis_tready does not take and the
// pending slot is full, s_axis_tready drops; nothing is lost or repeated.
module gaze_window_direction_vote #(
    parameter int WINDOW_LEN = gwdv_pkg::WINDOW_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // lsb up: left_x[13:0], left_y[27:14], right_x[41:28], right_y[55:42]
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lsb up: command_char[5:0], direction[8:6], cursor_left_x[22:9],
    // cursor_left_y[36:23], cursor_right_x[50:37], cursor_right_y[64:51], zero[71:65]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gwdv_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [gwdv_pkg::EDGE_W-1:0] i_cfg_data
);

    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam int CRW = gwdv_pkg::COORD_W;

    gwdv_pkg::t_cfg r_cfg;

    logic signed [CRW-1:0] lx, ly, rx, ry;
    logic signed [CRW-1:0] clx, cly, crx, cry;
    logic lx_ok, ly_ok, rx_ok, ry_ok, w_bad;
    logic w_accept, w_advance;

    logic [FW-1:0] r_fill;
    logic          r_pend;
    logic signed [CRW-1:0] r_plx, r_ply, r_prx, r_pry;
    logic [gwdv_pkg::DIR_W-1:0] r_held, w_dir;

    logic                        r_out_valid;
    logic [gwdv_pkg::CHAR_W-1:0] r_out_char;
    logic [gwdv_pkg::DIR_W-1:0]  r_out_dir;
    logic signed [CRW-1:0]       r_out_lx, r_out_ly, r_out_rx, r_out_ry;

    gwdv_pkg::t_entry w_chain [WINDOW_LEN+1];
    gwdv_pkg::t_flags w_flags [WINDOW_LEN];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_edge      <= 12'd720;
            r_cfg.right_edge     <= 12'd1840;
            r_cfg.top_edge       <= 12'd420;
            r_cfg.bottom_edge    <= 12'd1020;
            r_cfg.screen_width   <= 12'd2560;
            r_cfg.screen_height  <= 12'd1440;
            r_cfg.vote_threshold <= 4'd8;
            r_cfg.hold_threshold <= 4'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gwdv_pkg::REG_LEFT_EDGE:     r_cfg.left_edge     <= i_cfg_data;
                gwdv_pkg::REG_RIGHT_EDGE:    r_cfg.right_edge    <= i_cfg_data;
                gwdv_pkg::REG_TOP_EDGE:      r_cfg.top_edge      <= i_cfg_data;
                gwdv_pkg::REG_BOTTOM_EDGE:   r_cfg.bottom_edge   <= i_cfg_data;
                gwdv_pkg::REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                gwdv_pkg::REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                gwdv_pkg::REG_VOTE_THR:
                    r_cfg.vote_threshold <= i_cfg_data[gwdv_pkg::THR_W-1:0];
                gwdv_pkg::REG_HOLD_THR:
                    r_cfg.hold_threshold <= i_cfg_data[gwdv_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign lx = $signed(s_axis_tdata[13:0]);
    assign ly = $signed(s_axis_tdata[27:14]);
    assign rx = $signed(s_axis_tdata[41:28]);
    assign ry = $signed(s_axis_tdata[55:42]);

    assign lx_ok = (lx >= gwdv_pkg::COORD_MIN) && (lx <= gwdv_pkg::X_MAX);
    assign rx_ok = (rx >= gwdv_pkg::COORD_MIN) && (rx <= gwdv_pkg::X_MAX);
    assign ly_ok = (ly >= gwdv_pkg::COORD_MIN) && (ly <= gwdv_pkg::Y_MAX);
    assign ry_ok = (ry >= gwdv_pkg::COORD_MIN) && (ry <= gwdv_pkg::Y_MAX);

    assign w_bad = (!lx_ok && !rx_ok) || (!ly_ok && !ry_ok);

    // a bad eye copies the other eye
    assign clx = lx_ok ? lx : rx;
    assign crx = rx_ok ? rx : lx;
    assign cly = ly_ok ? ly : ry;
    assign cry = ry_ok ? ry : ly;

    assign w_advance     = r_pend && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_pend || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_chain[0].px   = w_bad ? '0 : clx;
        w_chain[0].py   = w_bad ? '0 : cly;
        w_chain[0].good = !w_bad;
    end

    genvar k;
    generate
        for (k = 0; k < WINDOW_LEN; k++) begin : g_cell
            gwdv_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_accept),
                .i_used  (FW'(k) < r_fill),
                .i_cfg   (r_cfg),
                .i_entry (w_chain[k]),
                .o_entry (w_chain[k+1]),
                .o_flags (w_flags[k])
            );
        end
    endgenerate

    gwdv_vote #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_vote (
        .i_flags (w_flags),
        .i_cfg   (r_cfg),
        .i_held  (r_held),
        .o_dir   (w_dir)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_held      <= gwdv_pkg::DIR_STOP;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && r_fill != FW'(WINDOW_LEN)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (w_accept) begin
                r_pend <= !w_bad;
            end else if (w_advance) begin
                r_pend <= 1'b0;
            end
            if (w_advance) begin
                r_held      <= w_dir;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the corrected sample until its vote is taken
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_bad) begin
            r_plx <= clx;
            r_ply <= cly;
            r_prx <= crx;
            r_pry <= cry;
        end
        if (w_advance) begin
            r_out_char <= gwdv_pkg::dir_char(w_dir);
            r_out_dir  <= w_dir;
            r_out_lx   <= r_plx;
            r_out_ly   <= r_ply;
            r_out_rx   <= r_prx;
            r_out_ry   <= r_pry;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_ry, r_out_rx, r_out_ly, r_out_lx,
                            r_out_dir, r_out_char};

endmodule

// ===== hdl/gwdv_cell.sv =====
module gwdv_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_used,
    input  gwdv_pkg::t_cfg  i_cfg,
    input  gwdv_pkg::t_entry i_entry,
    output gwdv_pkg::t_entry o_entry,
    output gwdv_pkg::t_flags o_flags
);

    gwdv_pkg::t_entry r_entry;

    logic signed [gwdv_pkg::COORD_W-1:0] w_le, w_re, w_te, w_be, w_sw, w_sh;
    logic x_ge0, x_lt_le, x_lt_re, x_lt_sw;
    logic y_ge0, y_lt_te, y_lt_be, y_lt_sh;
    logic x_lcol, x_ccol, x_rcol, y_trow, y_mrow, y_brow;
    logic w_live;

    // hand the entry to the older neighbor on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

    assign w_le = $signed({2'b00, i_cfg.left_edge});
    assign w_re = $signed({2'b00, i_cfg.right_edge});
    assign w_te = $signed({2'b00, i_cfg.top_edge});
    assign w_be = $signed({2'b00, i_cfg.bottom_edge});
    assign w_sw = $signed({2'b00, i_cfg.screen_width});
    assign w_sh = $signed({2'b00, i_cfg.screen_height});

    always_comb begin
        x_ge0   = r_entry.px >= 14'sd0;
        x_lt_le = r_entry.px < w_le;
        x_lt_re = r_entry.px < w_re;
        x_lt_sw = r_entry.px < w_sw;
        y_ge0   = r_entry.py >= 14'sd0;
        y_lt_te = r_entry.py < w_te;
        y_lt_be = r_entry.py < w_be;
        y_lt_sh = r_entry.py < w_sh;

        x_lcol = x_ge0 && x_lt_le;
        x_ccol = !x_lt_le && x_lt_re;
        x_rcol = !x_lt_re && x_lt_sw;
        y_trow = y_ge0 && y_lt_te;
        y_mrow = !y_lt_te && y_lt_be;
        y_brow = !y_lt_be && y_lt_sh;

        w_live = i_used && r_entry.good;

        o_flags.left    = w_live && x_lcol && y_mrow;
        o_flags.right   = w_live && x_rcol && y_mrow;
        o_flags.up      = w_live && x_ccol && y_trow;
        o_flags.down    = w_live && x_ccol && y_brow;
        o_flags.upleft  = w_live && x_lcol && y_trow;
        o_flags.upright = w_live && x_rcol && y_trow;
        // invalid marks count as off screen
        o_flags.out     = i_used && !(r_entry.good && x_ge0 && x_lt_sw && y_ge0 && y_lt_sh);
    end

endmodule

// ===== hdl/gwdv_vote.sv =====
module gwdv_vote #(
    parameter int WINDOW_LEN = gwdv_pkg::WINDOW_LEN_DEF
) (
    input  gwdv_pkg::t_flags                 i_flags [WINDOW_LEN],
    input  gwdv_pkg::t_cfg                   i_cfg,
    input  logic [gwdv_pkg::DIR_W-1:0]       i_held,
    output logic [gwdv_pkg::DIR_W-1:0]       o_dir
);

    localparam int CW = $clog2(WINDOW_LEN + 1);

    logic [WINDOW_LEN-1:0] v_l, v_r, v_u, v_d, v_lu, v_ru, v_out;
    logic [gwdv_pkg::THR_W-1:0] n_l, n_r, n_u, n_d, n_lu, n_ru, n_out;
    logic [gwdv_pkg::THR_W-1:0] vt, ht;

    always_comb begin
        for (int k = 0; k < WINDOW_LEN; k++) begin
            v_l[k]   = i_flags[k].left;
            v_r[k]   = i_flags[k].right;
            v_u[k]   = i_flags[k].up;
            v_d[k]   = i_flags[k].down;
            v_lu[k]  = i_flags[k].upleft;
            v_ru[k]  = i_flags[k].upright;
            v_out[k] = i_flags[k].out;
        end
    end

    assign n_l   = gwdv_pkg::THR_W'(CW'($countones(v_l)));
    assign n_r   = gwdv_pkg::THR_W'(CW'($countones(v_r)));
    assign n_u   = gwdv_pkg::THR_W'(CW'($countones(v_u)));
    assign n_d   = gwdv_pkg::THR_W'(CW'($countones(v_d)));
    assign n_lu  = gwdv_pkg::THR_W'(CW'($countones(v_lu)));
    assign n_ru  = gwdv_pkg::THR_W'(CW'($countones(v_ru)));
    assign n_out = gwdv_pkg::THR_W'(CW'($countones(v_out)));

    assign vt = i_cfg.vote_threshold;
    assign ht = i_cfg.hold_threshold;

    always_comb begin
        if (n_l > vt) begin
            o_dir = gwdv_pkg::DIR_LEFT;
        end else if (n_r > vt) begin
            o_dir = gwdv_pkg::DIR_RIGHT;
        end else if (n_u > vt) begin
            o_dir = gwdv_pkg::DIR_UP;
        end else if (n_d > vt) begin
            o_dir = gwdv_pkg::DIR_DOWN;
        end else if (n_lu > vt) begin
            o_dir = gwdv_pkg::DIR_UPLEFT;
        end else if (n_ru > vt) begin
            o_dir = gwdv_pkg::DIR_UPRIGHT;
        end else if (n_out > vt) begin
            o_dir = gwdv_pkg::DIR_BRAKE;
        end else if (i_held == gwdv_pkg::DIR_UP && n_u >= ht) begin
            o_dir = gwdv_pkg::DIR_UP;
        end else if (i_held == gwdv_pkg::DIR_DOWN && n_d >= ht) begin
            o_dir = gwdv_pkg::DIR_DOWN;
        end else begin
            o_dir = gwdv_pkg::DIR_STOP;
        end
    end

endmodule
